// ===== rtl/cpd_pkg.sv =====
// Shared types, constants and helpers for the cascaded PD position controller.
package cpd_pkg;

    // Field and datapath widths
    localparam int BYTE_W   = 8;
    localparam int GAIN_W   = 20;
    localparam int SP_W     = 10;
    localparam int POS_W    = 16;
    localparam int ERR_W    = 16;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = GAIN_W + DIFF_W - FRAC_W + 1;
    localparam int DRIVE_W  = 8;
    localparam int REF_W    = 12;
    localparam int DUTY_W   = 10;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam int HISTORY_DEPTH = 5;

    // Fixed operating points
    localparam int DUTY_X_MID = 767;
    localparam int DUTY_Y_MID = 795;
    localparam int U_LIMIT    = 100;
    localparam int ASCII_ZERO = 48;

    // Register reset values
    localparam logic [GAIN_W-1:0] OUTER_KP_X_RST = 20'd5243;
    localparam logic [GAIN_W-1:0] OUTER_KD_X_RST = 20'd328;
    localparam logic [GAIN_W-1:0] OUTER_KP_Y_RST = 20'd3932;
    localparam logic [GAIN_W-1:0] OUTER_KD_Y_RST = 20'd655;
    localparam logic [GAIN_W-1:0] INNER_KP_RST   = 20'd32768;
    localparam logic [GAIN_W-1:0] INNER_KD_RST   = 20'd229376;
    localparam logic [SP_W-1:0]   SETPOINT_RST   = 10'd175;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_OUTER_KP_X = 3'd0;
    localparam logic [2:0] REG_OUTER_KD_X = 3'd1;
    localparam logic [2:0] REG_OUTER_KP_Y = 3'd2;
    localparam logic [2:0] REG_OUTER_KD_Y = 3'd3;
    localparam logic [2:0] REG_INNER_KP   = 3'd4;
    localparam logic [2:0] REG_INNER_KD   = 3'd5;
    localparam logic [2:0] REG_SETPOINT_X = 3'd6;
    localparam logic [2:0] REG_SETPOINT_Y = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] x_hundreds;
        logic [BYTE_W-1:0] x_tens;
        logic [BYTE_W-1:0] x_ones;
        logic [BYTE_W-1:0] y_hundreds;
        logic [BYTE_W-1:0] y_tens;
        logic [BYTE_W-1:0] y_ones;
    } in_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_x;
        logic [DUTY_W-1:0] duty_y;
    } out_item_t;

    typedef struct packed {
        logic [GAIN_W-1:0] outer_kp_x;
        logic [GAIN_W-1:0] outer_kd_x;
        logic [GAIN_W-1:0] outer_kp_y;
        logic [GAIN_W-1:0] outer_kd_y;
        logic [GAIN_W-1:0] inner_kp;
        logic [GAIN_W-1:0] inner_kd;
        logic [SP_W-1:0]   setpoint_x;
        logic [SP_W-1:0]   setpoint_y;
    } cfg_t;

    // Three ASCII digits to a signed position; any byte is taken as it comes
    function automatic logic signed [POS_W-1:0] decode3(
        input logic [BYTE_W-1:0] h,
        input logic [BYTE_W-1:0] t,
        input logic [BYTE_W-1:0] o
    );
        logic signed [POS_W:0] dh;
        logic signed [POS_W:0] dt;
        logic signed [POS_W:0] d1;
        logic signed [POS_W:0] sum;
        dh  = $signed({9'd0, h}) - (POS_W+1)'(ASCII_ZERO);
        dt  = $signed({9'd0, t}) - (POS_W+1)'(ASCII_ZERO);
        d1  = $signed({9'd0, o}) - (POS_W+1)'(ASCII_ZERO);
        sum = d1 + (dt <<< 3) + (dt <<< 1) + (dh <<< 6) + (dh <<< 5) + (dh <<< 2);
        return sum[POS_W-1:0];
    endfunction

endpackage

// ===== rtl/cpd_cfg.sv =====
// APB-style register file holding the loop gains and setpoints.
module cpd_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cpd_pkg::ADDR_W-1:0]  paddr,
    input  logic [cpd_pkg::DATA_W-1:0]  pwdata,
    input  logic                        pready,
    output logic [cpd_pkg::DATA_W-1:0]  prdata,
    output cpd_pkg::cfg_t               cfg
);

    cpd_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    idx;

    assign wr_en = psel & penable & pwrite & pready;
    assign idx   = paddr[cpd_pkg::ADDR_W-1:2];
    assign cfg   = cfg_reg;

    // Register writes, masked to each register's width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.outer_kp_x <= cpd_pkg::OUTER_KP_X_RST;
            cfg_reg.outer_kd_x <= cpd_pkg::OUTER_KD_X_RST;
            cfg_reg.outer_kp_y <= cpd_pkg::OUTER_KP_Y_RST;
            cfg_reg.outer_kd_y <= cpd_pkg::OUTER_KD_Y_RST;
            cfg_reg.inner_kp   <= cpd_pkg::INNER_KP_RST;
            cfg_reg.inner_kd   <= cpd_pkg::INNER_KD_RST;
            cfg_reg.setpoint_x <= cpd_pkg::SETPOINT_RST;
            cfg_reg.setpoint_y <= cpd_pkg::SETPOINT_RST;
        end else if (wr_en) begin
            case (idx)
                cpd_pkg::REG_OUTER_KP_X: cfg_reg.outer_kp_x <= pwdata[cpd_pkg::GAIN_W-1:0];
                cpd_pkg::REG_OUTER_KD_X: cfg_reg.outer_kd_x <= pwdata[cpd_pkg::GAIN_W-1:0];
                cpd_pkg::REG_OUTER_KP_Y: cfg_reg.outer_kp_y <= pwdata[cpd_pkg::GAIN_W-1:0];
                cpd_pkg::REG_OUTER_KD_Y: cfg_reg.outer_kd_y <= pwdata[cpd_pkg::GAIN_W-1:0];
                cpd_pkg::REG_INNER_KP:   cfg_reg.inner_kp   <= pwdata[cpd_pkg::GAIN_W-1:0];
                cpd_pkg::REG_INNER_KD:   cfg_reg.inner_kd   <= pwdata[cpd_pkg::GAIN_W-1:0];
                cpd_pkg::REG_SETPOINT_X: cfg_reg.setpoint_x <= pwdata[cpd_pkg::SP_W-1:0];
                cpd_pkg::REG_SETPOINT_Y: cfg_reg.setpoint_y <= pwdata[cpd_pkg::SP_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        case (idx)
            cpd_pkg::REG_OUTER_KP_X: prdata[cpd_pkg::GAIN_W-1:0] = cfg_reg.outer_kp_x;
            cpd_pkg::REG_OUTER_KD_X: prdata[cpd_pkg::GAIN_W-1:0] = cfg_reg.outer_kd_x;
            cpd_pkg::REG_OUTER_KP_Y: prdata[cpd_pkg::GAIN_W-1:0] = cfg_reg.outer_kp_y;
            cpd_pkg::REG_OUTER_KD_Y: prdata[cpd_pkg::GAIN_W-1:0] = cfg_reg.outer_kd_y;
            cpd_pkg::REG_INNER_KP:   prdata[cpd_pkg::GAIN_W-1:0] = cfg_reg.inner_kp;
            cpd_pkg::REG_INNER_KD:   prdata[cpd_pkg::GAIN_W-1:0] = cfg_reg.inner_kd;
            cpd_pkg::REG_SETPOINT_X: prdata[cpd_pkg::SP_W-1:0]   = cfg_reg.setpoint_x;
            cpd_pkg::REG_SETPOINT_Y: prdata[cpd_pkg::SP_W-1:0]   = cfg_reg.setpoint_y;
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== rtl/cpd_mul.sv =====
// Shared Q4.16 gain multiplier, truncating toward zero, registered output.
module cpd_mul (
    input  logic                               aclk,
    input  logic                               load,
    input  logic [cpd_pkg::GAIN_W-1:0]         gain,
    input  logic signed [cpd_pkg::DIFF_W-1:0]  operand,
    output logic signed [cpd_pkg::PROD_W-1:0]  product
);

    localparam int FULL_W = cpd_pkg::GAIN_W + cpd_pkg::DIFF_W;
    localparam int MAG_W  = cpd_pkg::PROD_W - 1;

    logic [cpd_pkg::DIFF_W-1:0] mag;
    logic [FULL_W-1:0]          full;
    logic [MAG_W-1:0]           trunc;
    logic [cpd_pkg::PROD_W-1:0] result;
    logic [cpd_pkg::PROD_W-1:0] product_reg;

    // Sign-magnitude multiply so the shift truncates toward zero
    assign mag    = operand[cpd_pkg::DIFF_W-1] ? (~operand + 1'b1) : operand;
    assign full   = FULL_W'(mag) * FULL_W'(gain);
    assign trunc  = full[FULL_W-1:cpd_pkg::FRAC_W];
    assign result = operand[cpd_pkg::DIFF_W-1] ? (~{1'b0, trunc} + 1'b1) : {1'b0, trunc};

    always_ff @(posedge aclk) begin
        if (load) begin
            product_reg <= result;
        end
    end

    assign product = $signed(product_reg);

endmodule

// ===== rtl/cascaded_pd_position_control_unit.sv =====
// Top level: frame decode, PD sequencer, error histories and result register.
//
// Usage:
//  - Input channel s_valid/s_ready/s_data carries one camera frame per transfer
//    (three ASCII digit bytes per axis). Result channel m_valid/m_ready/m_data
//    carries one duty pair per frame.
//  - Configuration through the APB-style port: eight registers at byte
//    addresses 0x00..0x1C; pready is tied high. Write only while idle.
//  - The outer loop runs on frames 1, 3, 5, ... after reset, the inner loop
//    on every frame. Each PD evaluation steps through error, P product,
//    D product, and sum and saturate on the single shared multiplier.
//  - s_ready is low while a frame is computed and returns the cycle after the
//    result is loaded, so a new frame is taken only once the last one is
//    finished.
//  - If the receiver stalls, the finished result waits in the output
//    register; the next frame is still accepted and computed, and only its
//    final load waits until the held result has been taken.
//  - Synchronous active-low reset clears gains and setpoints to defaults,
//    error histories and inner references to zero, and starts with the
//    outer loop.
module cascaded_pd_position_control_unit #(
    parameter int HISTORY_DEPTH = cpd_pkg::HISTORY_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  cpd_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output cpd_pkg::out_item_t          m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cpd_pkg::ADDR_W-1:0]  paddr,
    input  logic [cpd_pkg::DATA_W-1:0]  pwdata,
    output logic [cpd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int OLD_TAP = HISTORY_DEPTH - 2;
    localparam int ERR_W   = cpd_pkg::ERR_W;
    localparam int DIFF_W  = cpd_pkg::DIFF_W;
    localparam int PROD_W  = cpd_pkg::PROD_W;
    localparam int DRV_W   = cpd_pkg::DRIVE_W;
    localparam int REF_W   = cpd_pkg::REF_W;
    localparam int GAIN_W  = cpd_pkg::GAIN_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ERR  = 5'b00010,
        ST_MULP = 5'b00100,
        ST_MULD = 5'b01000,
        ST_SAT  = 5'b10000
    } state_t;

    localparam logic [1:0] JOB_OUTER_X = 2'd0;
    localparam logic [1:0] JOB_OUTER_Y = 2'd1;
    localparam logic [1:0] JOB_INNER_X = 2'd2;
    localparam logic [1:0] JOB_INNER_Y = 2'd3;

    cpd_pkg::cfg_t cfg;

    state_t                     state_reg, state_next;
    logic [1:0]                 job_reg;
    logic                       phase_reg;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    cpd_pkg::out_item_t         m_data_reg;
    logic signed [ERR_W-1:0]    px_reg, py_reg;
    logic signed [ERR_W-1:0]    e_reg;
    logic signed [DIFF_W-1:0]   d_reg;
    logic signed [PROD_W-1:0]   p_reg;
    logic signed [DRV_W-1:0]    ux_reg;
    logic signed [REF_W-1:0]    ref_x_reg, ref_y_reg;
    logic signed [ERR_W-1:0]    hist_reg [4][HISTORY_DEPTH];

    logic                       in_xfer;
    logic                       out_free;
    logic signed [ERR_W-1:0]    pos_sel;
    logic signed [REF_W-1:0]    ref_sel;
    logic [cpd_pkg::SP_W-1:0]   sp_sel;
    logic signed [ERR_W:0]      err_full;
    logic signed [ERR_W-1:0]    err;
    logic signed [ERR_W-1:0]    old_tap;
    logic signed [DIFF_W-1:0]   d_full;
    logic [GAIN_W-1:0]          kp_sel, kd_sel;
    logic                       mul_load;
    logic [GAIN_W-1:0]          mul_gain;
    logic signed [DIFF_W-1:0]   mul_operand;
    logic signed [PROD_W-1:0]   mul_prod;
    logic signed [PROD_W:0]     pd_sum;
    logic signed [DRV_W-1:0]    u_sat;
    logic signed [REF_W-1:0]    ref_new;
    logic [cpd_pkg::DUTY_W:0]   duty_x_full, duty_y_full;

    cpd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    cpd_mul u_mul (
        .aclk    (aclk),
        .load    (mul_load),
        .gain    (mul_gain),
        .operand (mul_operand),
        .product (mul_prod)
    );

    assign pready   = 1'b1;
    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid & s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = ~m_valid_reg | m_ready;

    // Operand selection for the current job
    always_comb begin
        sp_sel  = job_reg[0] ? cfg.setpoint_y : cfg.setpoint_x;
        pos_sel = job_reg[0] ? py_reg : px_reg;
        if (job_reg[1]) begin
            ref_sel = job_reg[0] ? ref_y_reg : ref_x_reg;
        end else begin
            ref_sel = $signed({2'b00, sp_sel});
        end
        case (job_reg)
            JOB_OUTER_X: begin kp_sel = cfg.outer_kp_x; kd_sel = cfg.outer_kd_x; end
            JOB_OUTER_Y: begin kp_sel = cfg.outer_kp_y; kd_sel = cfg.outer_kd_y; end
            JOB_INNER_X: begin kp_sel = cfg.inner_kp;   kd_sel = cfg.inner_kd;   end
            JOB_INNER_Y: begin kp_sel = cfg.inner_kp;   kd_sel = cfg.inner_kd;   end
            default:     begin kp_sel = cfg.inner_kp;   kd_sel = cfg.inner_kd;   end
        endcase
    end

    // New error and derivative against the entry that becomes the oldest
    assign err_full = {pos_sel[ERR_W-1], pos_sel}
                    - {{(ERR_W+1-REF_W){ref_sel[REF_W-1]}}, ref_sel};
    assign err      = err_full[ERR_W-1:0];
    assign old_tap  = hist_reg[job_reg][OLD_TAP];
    assign d_full   = {err[ERR_W-1], err} - {old_tap[ERR_W-1], old_tap};

    // Shared multiplier issue
    assign mul_load    = (state_reg == ST_MULP) | (state_reg == ST_MULD);
    assign mul_gain    = (state_reg == ST_MULP) ? kp_sel : kd_sel;
    assign mul_operand = (state_reg == ST_MULP) ? {e_reg[ERR_W-1], e_reg} : d_reg;

    // P plus D, saturated to the drive range
    assign pd_sum = {p_reg[PROD_W-1], p_reg} + {mul_prod[PROD_W-1], mul_prod};
    always_comb begin
        if (pd_sum > (PROD_W+1)'(cpd_pkg::U_LIMIT)) begin
            u_sat = DRV_W'(cpd_pkg::U_LIMIT);
        end else if (pd_sum < -(PROD_W+1)'(cpd_pkg::U_LIMIT)) begin
            u_sat = -DRV_W'(cpd_pkg::U_LIMIT);
        end else begin
            u_sat = pd_sum[DRV_W-1:0];
        end
    end

    assign ref_new     = $signed({2'b00, sp_sel}) - {{(REF_W-DRV_W){u_sat[DRV_W-1]}}, u_sat};
    assign duty_x_full = (cpd_pkg::DUTY_W+1)'(cpd_pkg::DUTY_X_MID)
                       - {{(cpd_pkg::DUTY_W+1-DRV_W){ux_reg[DRV_W-1]}}, ux_reg};
    assign duty_y_full = (cpd_pkg::DUTY_W+1)'(cpd_pkg::DUTY_Y_MID)
                       + {{(cpd_pkg::DUTY_W+1-DRV_W){u_sat[DRV_W-1]}}, u_sat};

    // Result valid: cleared on a transfer, set when the last drive is loaded
    always_comb begin
        m_valid_next = m_valid_reg & ~m_ready;
        if (state_reg == ST_SAT && job_reg == JOB_INNER_Y && out_free) begin
            m_valid_next = 1'b1;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_xfer) state_next = ST_ERR;
            ST_ERR:  state_next = ST_MULP;
            ST_MULP: state_next = ST_MULD;
            ST_MULD: state_next = ST_SAT;
            ST_SAT: begin
                if (job_reg != JOB_INNER_Y) begin
                    state_next = ST_ERR;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, histories and inner references
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            job_reg     <= JOB_OUTER_X;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            ref_x_reg   <= '0;
            ref_y_reg   <= '0;
            for (int j = 0; j < 4; j++) begin
                for (int k = 0; k < HISTORY_DEPTH; k++) begin
                    hist_reg[j][k] <= '0;
                end
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (in_xfer) begin
                phase_reg <= ~phase_reg;
                job_reg   <= phase_reg ? JOB_INNER_X : JOB_OUTER_X;
            end
            if (state_reg == ST_ERR) begin
                for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
                    hist_reg[job_reg][k] <= hist_reg[job_reg][k-1];
                end
                hist_reg[job_reg][0] <= err;
            end
            if (state_reg == ST_SAT) begin
                case (job_reg)
                    JOB_OUTER_X: begin ref_x_reg <= ref_new; job_reg <= JOB_OUTER_Y; end
                    JOB_OUTER_Y: begin ref_y_reg <= ref_new; job_reg <= JOB_INNER_X; end
                    JOB_INNER_X: job_reg <= JOB_INNER_Y;
                    default: ;
                endcase
            end
        end
    end

    // Datapath payload registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            px_reg <= cpd_pkg::decode3(s_data.x_hundreds, s_data.x_tens, s_data.x_ones);
            py_reg <= cpd_pkg::decode3(s_data.y_hundreds, s_data.y_tens, s_data.y_ones);
        end
        if (state_reg == ST_ERR) begin
            e_reg <= err;
            d_reg <= d_full;
        end
        if (state_reg == ST_MULD) begin
            p_reg <= mul_prod;
        end
        if (state_reg == ST_SAT && job_reg == JOB_INNER_X) begin
            ux_reg <= u_sat;
        end
        if (state_reg == ST_SAT && job_reg == JOB_INNER_Y && out_free) begin
            m_data_reg.duty_x <= duty_x_full[cpd_pkg::DUTY_W-1:0];
            m_data_reg.duty_y <= duty_y_full[cpd_pkg::DUTY_W-1:0];
        end
    end

    // Checks
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == ST_ERR))
        else $error("frame transfer did not start the sequencer");

    a_outer_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ERR && !job_reg[1]) |-> phase_reg)
        else $error("outer loop ran on an inner-only frame");

    a_ref_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ref_x_reg >= -REF_W'(cpd_pkg::U_LIMIT)) && (ref_y_reg >= -REF_W'(cpd_pkg::U_LIMIT)))
        else $error("inner reference below saturation bound");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("held result overwritten");

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.duty_x >= 10'd667 && m_data_reg.duty_x <= 10'd867
                         && m_data_reg.duty_y >= 10'd695 && m_data_reg.duty_y <= 10'd895))
        else $error("duty outside saturated range");

endmodule

// ===== sim/cascaded_pd_position_control_unit_tb.sv =====
// Self-checking testbench for the cascaded PD position controller: frames in, duty pairs out.
`timescale 1ns / 1ps

module cascaded_pd_position_control_unit_tb;
    import cpd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_IDLE    = 11;
    localparam int SETTLE_WAIT = 40;
    localparam int REPORT_MAX  = 10;

    // Error history slots of the predictor
    localparam int LOOP_OUTER_X = 0;
    localparam int LOOP_OUTER_Y = 1;
    localparam int LOOP_INNER_X = 2;
    localparam int LOOP_INNER_Y = 3;
    localparam int LOOP_COUNT   = 4;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_item_t            s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_item_t           m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    cascaded_pd_position_control_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow copy of the gains and setpoints
    logic [GAIN_W-1:0] gain_kp_ox = OUTER_KP_X_RST;
    logic [GAIN_W-1:0] gain_kd_ox = OUTER_KD_X_RST;
    logic [GAIN_W-1:0] gain_kp_oy = OUTER_KP_Y_RST;
    logic [GAIN_W-1:0] gain_kd_oy = OUTER_KD_Y_RST;
    logic [GAIN_W-1:0] gain_kp_in = INNER_KP_RST;
    logic [GAIN_W-1:0] gain_kd_in = INNER_KD_RST;
    logic [SP_W-1:0]   target_x   = SETPOINT_RST;
    logic [SP_W-1:0]   target_y   = SETPOINT_RST;

    // Controller state as predicted
    logic signed [ERR_W-1:0] err_hist [LOOP_COUNT][HISTORY_DEPTH];
    logic signed [REF_W-1:0] inner_target_x = '0;
    logic signed [REF_W-1:0] inner_target_y = '0;
    logic                    run_outer_next = 1'b0;

    in_item_t  frame_q [$];
    out_item_t duty_expect_q [$];

    int  fail_count     = 0;
    int  cycle_count    = 0;
    int  gap_left       = 0;
    int  stall_left     = 0;
    int  stall_draw;
    bit  sender_paced   = 1'b1;
    bit  receiver_paced = 1'b1;

    initial begin
        for (int l = 0; l < LOOP_COUNT; l++)
            for (int k = 0; k < HISTORY_DEPTH; k++)
                err_hist[l][k] = '0;
    end

    function automatic int digit_val(logic [BYTE_W-1:0] b);
        return int'({24'd0, b}) - ASCII_ZERO;
    endfunction

    // Q4.16 gain times value, truncated toward zero
    function automatic longint gain_scale(logic [GAIN_W-1:0] g, int v);
        longint mag;
        longint prod;
        mag  = (v < 0) ? -longint'(v) : longint'(v);
        prod = (mag * longint'({44'd0, g})) >>> FRAC_W;
        return (v < 0) ? -prod : prod;
    endfunction

    function automatic int clamp_drive(longint u);
        if (u < -U_LIMIT) return -U_LIMIT;
        if (u > U_LIMIT) return U_LIMIT;
        return int'(u);
    endfunction

    // Shift in the newest error and return the saturated PD drive
    function automatic int pd_drive(int loop, int err, logic [GAIN_W-1:0] kp,
                                    logic [GAIN_W-1:0] kd);
        int k;
        for (k = HISTORY_DEPTH - 1; k > 0; k--)
            err_hist[loop][k] = err_hist[loop][k-1];
        err_hist[loop][0] = ERR_W'(err);
        return clamp_drive(gain_scale(kp, err)
                           + gain_scale(kd, err - int'(err_hist[loop][HISTORY_DEPTH-1])));
    endfunction

    // Advance the predicted controller by one frame and give its duty pair
    function automatic out_item_t predict_duty(in_item_t f);
        int px;
        int py;
        int ox;
        int oy;
        int ux;
        int uy;
        out_item_t r;
        px = digit_val(f.x_ones) + 10 * digit_val(f.x_tens) + 100 * digit_val(f.x_hundreds);
        py = digit_val(f.y_ones) + 10 * digit_val(f.y_tens) + 100 * digit_val(f.y_hundreds);
        if (!run_outer_next) begin
            ox = pd_drive(LOOP_OUTER_X, px - int'(target_x), gain_kp_ox, gain_kd_ox);
            oy = pd_drive(LOOP_OUTER_Y, py - int'(target_y), gain_kp_oy, gain_kd_oy);
            inner_target_x = REF_W'(int'(target_x) - ox);
            inner_target_y = REF_W'(int'(target_y) - oy);
        end
        run_outer_next = ~run_outer_next;
        ux = pd_drive(LOOP_INNER_X, px - int'(inner_target_x), gain_kp_in, gain_kd_in);
        uy = pd_drive(LOOP_INNER_Y, py - int'(inner_target_y), gain_kp_in, gain_kd_in);
        r.duty_x = DUTY_W'(DUTY_X_MID - ux);
        r.duty_y = DUTY_W'(DUTY_Y_MID + uy);
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] ascii_digit(int d);
        return BYTE_W'(ASCII_ZERO + d);
    endfunction

    function automatic in_item_t digits_frame(int px, int py);
        in_item_t f;
        f.x_hundreds = ascii_digit(px / 100);
        f.x_tens     = ascii_digit((px / 10) % 10);
        f.x_ones     = ascii_digit(px % 10);
        f.y_hundreds = ascii_digit(py / 100);
        f.y_tens     = ascii_digit((py / 10) % 10);
        f.y_ones     = ascii_digit(py % 10);
        return f;
    endfunction

    function automatic int near_target(logic [SP_W-1:0] sp);
        int p;
        p = int'(sp) + $urandom_range(0, 80) - 40;
        if (p < 0) p = 0;
        if (p > 999) p = 999;
        return p;
    endfunction

    // Mostly well-formed digit frames, some near the target, some raw byte noise or one bad byte
    function automatic in_item_t random_frame();
        in_item_t f;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
            f = digits_frame($urandom_range(0, 999), $urandom_range(0, 999));
        end else if (pick <= 7) begin
            f = digits_frame(near_target(target_x), near_target(target_y));
        end else if (pick == 8) begin
            f = in_item_t'({$urandom(), 16'($urandom())});
        end else begin
            f = digits_frame($urandom_range(0, 999), $urandom_range(0, 999));
            case ($urandom_range(0, 5))
                0: f.x_hundreds = BYTE_W'($urandom());
                1: f.x_tens     = BYTE_W'($urandom());
                2: f.x_ones     = BYTE_W'($urandom());
                3: f.y_hundreds = BYTE_W'($urandom());
                4: f.y_tens     = BYTE_W'($urandom());
                default: f.y_ones = BYTE_W'($urandom());
            endcase
        end
        return f;
    endfunction

    // APB write: setup cycle, access cycle, register takes it on the following edge
    task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OUTER_KP_X: gain_kp_ox = value[GAIN_W-1:0];
            REG_OUTER_KD_X: gain_kd_ox = value[GAIN_W-1:0];
            REG_OUTER_KP_Y: gain_kp_oy = value[GAIN_W-1:0];
            REG_OUTER_KD_Y: gain_kd_oy = value[GAIN_W-1:0];
            REG_INNER_KP:   gain_kp_in = value[GAIN_W-1:0];
            REG_INNER_KD:   gain_kd_in = value[GAIN_W-1:0];
            REG_SETPOINT_X: target_x   = value[SP_W-1:0];
            REG_SETPOINT_Y: target_y   = value[SP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all_gains(logic [DATA_W-1:0] value);
        write_reg(REG_OUTER_KP_X, value);
        write_reg(REG_OUTER_KD_X, value);
        write_reg(REG_OUTER_KP_Y, value);
        write_reg(REG_OUTER_KD_Y, value);
        write_reg(REG_INNER_KP, value);
        write_reg(REG_INNER_KD, value);
    endtask

    function automatic logic [DATA_W-1:0] random_gain();
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return DATA_W'($urandom_range(0, 262143));
    endfunction

    function automatic logic [DATA_W-1:0] random_target();
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return DATA_W'($urandom_range(0, 1023));
    endfunction

    // Block until every queued frame is taken and every duty pair has come back
    task automatic wait_drained();
        @(negedge aclk);
        while (frame_q.size() != 0 || s_valid || duty_expect_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_WAIT) @(negedge aclk);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            frame_q.push_back(random_frame());
    endtask

    // Sender: one frame per transfer, random gap after each when paced
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready)
                duty_expect_q.push_back(predict_duty(s_data));
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (frame_q.size() != 0) begin
                    s_data   <= frame_q.pop_front();
                    s_valid  <= 1'b1;
                    gap_left <= sender_paced ? $urandom_range(0, MAX_IDLE) : 0;
                end else begin
                    s_valid  <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each duty pair, then a random stall when paced
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (m_valid && m_ready) begin
            if (duty_expect_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result: duty_x=%0d duty_y=%0d",
                             m_data.duty_x, m_data.duty_y);
            end else begin
                out_item_t want;
                want = duty_expect_q.pop_front();
                if (m_data.duty_x !== want.duty_x || m_data.duty_y !== want.duty_y) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("mismatch: duty_x exp %0d got %0d, duty_y exp %0d got %0d",
                                 want.duty_x, m_data.duty_x, want.duty_y, m_data.duty_y);
                end
            end
            stall_draw = receiver_paced ? $urandom_range(0, MAX_IDLE) : 0;
            stall_left <= stall_draw;
            m_ready    <= (stall_draw == 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= (stall_left == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: code extremes, target hits, and a ramp long enough to fill the histories
        @(negedge aclk);
        frame_q.push_back(digits_frame(0, 0));
        frame_q.push_back(digits_frame(999, 999));
        frame_q.push_back(digits_frame(175, 175));
        frame_q.push_back(digits_frame(175, 175));
        frame_q.push_back(digits_frame(0, 999));
        frame_q.push_back(digits_frame(999, 0));
        frame_q.push_back(in_item_t'({48{1'b0}}));
        frame_q.push_back(in_item_t'({48{1'b1}}));
        frame_q.push_back(in_item_t'({{24{1'b1}}, {24{1'b0}}}));
        frame_q.push_back(in_item_t'({{24{1'b0}}, {24{1'b1}}}));
        for (int k = 0; k < 12; k++)
            frame_q.push_back(digits_frame(100 + 10 * k, 250 - 10 * k));
        wait_drained();

        // Reset gains, sender and receiver both paced
        queue_random(300);
        wait_drained();

        // Largest gains, setpoints beyond 999; the top bits exercise masking
        sender_paced   = 1'b0;
        receiver_paced = 1'b0;
        write_all_gains(32'hFFFF_FFFF);
        write_reg(REG_SETPOINT_X, 32'hFFFF_FFFF);
        write_reg(REG_SETPOINT_Y, 32'hFFFF_FFFF);
        @(negedge aclk);
        queue_random(200);
        wait_drained();

        // All gains and setpoints zero
        sender_paced   = 1'b1;
        receiver_paced = 1'b0;
        write_all_gains(32'hFFF0_0000);
        write_reg(REG_SETPOINT_X, 32'hFFFF_FC00);
        write_reg(REG_SETPOINT_Y, 32'hFFFF_FC00);
        @(negedge aclk);
        queue_random(200);
        wait_drained();

        // Random settings, pacing varied per phase
        for (int p = 0; p < 7; p++) begin
            sender_paced   = (p % 3) != 1;
            receiver_paced = (p % 2) == 0;
            write_reg(REG_OUTER_KP_X, random_gain());
            write_reg(REG_OUTER_KD_X, random_gain());
            write_reg(REG_OUTER_KP_Y, random_gain());
            write_reg(REG_OUTER_KD_Y, random_gain());
            write_reg(REG_INNER_KP, random_gain());
            write_reg(REG_INNER_KD, random_gain());
            write_reg(REG_SETPOINT_X, random_target());
            write_reg(REG_SETPOINT_Y, random_target());
            @(negedge aclk);
            queue_random(180);
            wait_drained();
        end

        fail_count += duty_expect_q.size();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
